FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the tachometer RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

FILE: hw/rtl/etc_pkg.sv
// Types, codes and widths of the encoder tachometer.
// No dependencies; used by every module of the block.
`default_nettype none

package etc_pkg;

    // running pulse count width
    localparam int COUNT_BITS = 32;

    localparam int PPR_W   = 17;
    localparam int SCALE_W = 24;
    localparam int NUM_W   = COUNT_BITS + SCALE_W;
    localparam int DEN_W   = 32 + PPR_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // 60000 * 256
    localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(15360000);
    localparam logic [PPR_W-1:0]   CAL_MAX   = '1;
    localparam logic [PPR_W-1:0]   PPR_MAX   = PPR_W'(100000);
    localparam logic [15:0]        PERIOD_RESET = 16'd100;

    localparam logic [1:0] CMD_EDGE   = 2'd0;
    localparam logic [1:0] CMD_TIME   = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STARTED = 3'd1;
    localparam logic [2:0] ST_ALREADY = 3'd2;
    localparam logic [2:0] ST_NOT_CAL = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_SAVED   = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_EDGE,
        KIND_TIME,
        KIND_START,
        KIND_FINISH
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        b_level;
        logic [31:0] now_ms;
    } item_t;

    // queue handshake toward the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

endpackage

`default_nettype wire

FILE: hw/rtl/etc_front.sv
// Front end: takes requests, decodes the command into an item kind.
// Depends on etc_pkg; feeds etc_queue.
`default_nettype none

module etc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    cmd,
    input  wire logic          b_level,
    input  wire logic [31:0]   now_ms,
    input  wire logic          q_full,
    output logic               push,
    output etc_pkg::item_t     push_item
);

    logic           front_valid_reg;
    etc_pkg::item_t front_item_reg;
    etc_pkg::kind_t kind;
    logic           accept;

    always_comb
    begin
        case (cmd)
            etc_pkg::CMD_EDGE:  kind = etc_pkg::KIND_EDGE;
            etc_pkg::CMD_TIME:  kind = etc_pkg::KIND_TIME;
            etc_pkg::CMD_START: kind = etc_pkg::KIND_START;
            default:            kind = etc_pkg::KIND_FINISH;
        endcase
    end

    assign in_stall  = front_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_item = front_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            front_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            front_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg.kind    <= kind;
            front_item_reg.b_level <= b_level;
            front_item_reg.now_ms  <= now_ms;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/etc_queue.sv
// Short FIFO of decoded items between front and back end.
// Depends on etc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module etc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire etc_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output etc_pkg::qhead_t     head
);

    etc_pkg::item_t                 entry_reg [etc_pkg::QUEUE_DEPTH];
    logic [etc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [etc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [etc_pkg::QCNT_W-1:0]     count_reg;

    assign full = (count_reg == etc_pkg::QCNT_W'(etc_pkg::QUEUE_DEPTH));
    assign head = '{valid: (count_reg != '0), item: entry_reg[rd_ptr_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == etc_pkg::QPTR_W'(etc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == etc_pkg::QPTR_W'(etc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !head.valid, "pop from empty queue")
    `ASSERT_AT(a_count_bound, clk, rst_n,
               count_reg <= etc_pkg::QCNT_W'(etc_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

FILE: hw/rtl/etc_back.sv
// Back end: counter state, calibration, speed sample with restoring divider,
// result register. Depends on etc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module etc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    input  wire etc_pkg::qhead_t     head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               status,
    output logic [31:0]              rpm_q8,
    output logic signed [31:0]       position_count,
    output logic                     is_calibrating,
    output logic                     is_calibrated,
    output logic [16:0]              pulses_per_rev
);

    localparam int CB = etc_pkg::COUNT_BITS;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_FIN
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [15:0]                 period_reg;
    logic [CB-1:0]               pulse_reg, pulse_next;
    logic [CB-1:0]               win_cnt_reg, win_cnt_next;
    logic [31:0]                 win_ms_reg, win_ms_next;
    logic [etc_pkg::PPR_W-1:0]   calib_reg, calib_next;
    logic                        active_reg, active_next;
    logic [etc_pkg::PPR_W-1:0]   ppr_reg, ppr_next;
    logic [31:0]                 speed_reg, speed_next;

    logic [CB-1:0]               mag_reg, mag_next;
    logic [31:0]                 elapsed_reg, elapsed_next;
    logic [31:0]                 snap_now_reg, snap_now_next;
    logic [etc_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [etc_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [etc_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [etc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  status_reg, status_next;
    logic [31:0]                 rpm_reg;
    logic signed [31:0]          pos_reg;
    logic                        calibrating_reg;
    logic                        calibrated_reg;
    logic [etc_pkg::PPR_W-1:0]   ppr_out_reg;

    logic                        out_free;
    logic                        out_load;
    logic [31:0]                 elapsed;
    logic [CB-1:0]               delta;
    logic [CB-1:0]               mag;
    logic [etc_pkg::DEN_W:0]     trial;
    logic [etc_pkg::DEN_W:0]     diff;
    logic                        ge;
    logic [31:0]                 sat_rpm;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head.valid && (state_reg == B_IDLE) && out_free;

    assign elapsed = head.item.now_ms - win_ms_reg;
    assign delta   = pulse_reg - win_cnt_reg;
    assign mag     = delta[CB-1] ? (~delta + CB'(1)) : delta;

    // one quotient bit per cycle
    assign trial = {rem_reg, num_reg[etc_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign sat_rpm = (|num_reg[etc_pkg::NUM_W-1:32]) ? '1 : num_reg[31:0];

    always_comb
    begin
        state_next     = state_reg;
        pulse_next     = pulse_reg;
        win_cnt_next   = win_cnt_reg;
        win_ms_next    = win_ms_reg;
        calib_next     = calib_reg;
        active_next    = active_reg;
        ppr_next       = ppr_reg;
        speed_next     = speed_reg;
        mag_next       = mag_reg;
        elapsed_next   = elapsed_reg;
        snap_now_next  = snap_now_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        status_next    = etc_pkg::ST_OK;
        out_load       = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    out_load = 1'b1;
                    case (head.item.kind)
                        etc_pkg::KIND_EDGE:
                        begin
                            pulse_next = head.item.b_level ? pulse_reg - CB'(1)
                                                           : pulse_reg + CB'(1);
                            if (active_reg && (calib_reg != etc_pkg::CAL_MAX))
                            begin
                                calib_next = calib_reg + 1'b1;
                            end
                        end
                        etc_pkg::KIND_TIME:
                        begin
                            if ((elapsed == '0) || (ppr_reg == '0))
                            begin
                                speed_next = '0;
                            end
                            else if (elapsed >= {16'h0, period_reg})
                            begin
                                out_load      = 1'b0;
                                mag_next      = mag;
                                elapsed_next  = elapsed;
                                snap_now_next = head.item.now_ms;
                                state_next    = B_MUL;
                            end
                        end
                        etc_pkg::KIND_START:
                        begin
                            if (active_reg)
                            begin
                                status_next = etc_pkg::ST_ALREADY;
                            end
                            else
                            begin
                                calib_next  = '0;
                                active_next = 1'b1;
                                status_next = etc_pkg::ST_STARTED;
                            end
                        end
                        default:
                        begin
                            if (!active_reg)
                            begin
                                status_next = etc_pkg::ST_NOT_CAL;
                            end
                            else
                            begin
                                active_next  = 1'b0;
                                win_cnt_next = pulse_reg;
                                win_ms_next  = head.item.now_ms;
                                speed_next   = '0;
                                if ((calib_reg == '0) || (calib_reg > etc_pkg::PPR_MAX))
                                begin
                                    status_next = etc_pkg::ST_INVALID;
                                end
                                else
                                begin
                                    ppr_next    = calib_reg;
                                    status_next = etc_pkg::ST_SAVED;
                                end
                            end
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                num_next   = etc_pkg::NUM_W'(mag_reg) * etc_pkg::NUM_W'(etc_pkg::RPM_SCALE);
                den_next   = etc_pkg::DEN_W'(elapsed_reg) * etc_pkg::DEN_W'(ppr_reg);
                rem_next   = '0;
                cnt_next   = etc_pkg::DIV_CNT_W'(etc_pkg::NUM_W - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next = ge ? diff[etc_pkg::DEN_W-1:0] : trial[etc_pkg::DEN_W-1:0];
                num_next = {num_reg[etc_pkg::NUM_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    state_next = B_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                // num_reg now holds the quotient
                if (out_free)
                begin
                    speed_next   = sat_rpm;
                    win_cnt_next = pulse_reg;
                    win_ms_next  = snap_now_reg;
                    out_load     = 1'b1;
                    state_next   = B_IDLE;
                end
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            period_reg      <= etc_pkg::PERIOD_RESET;
            pulse_reg       <= '0;
            win_cnt_reg     <= '0;
            win_ms_reg      <= '0;
            calib_reg       <= '0;
            active_reg      <= 1'b0;
            ppr_reg         <= '0;
            speed_reg       <= '0;
            out_valid_reg   <= 1'b0;
            mag_reg         <= '0;
            elapsed_reg     <= '0;
            snap_now_reg    <= '0;
            num_reg         <= '0;
            den_reg         <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            status_reg      <= etc_pkg::ST_OK;
            rpm_reg         <= '0;
            pos_reg         <= '0;
            calibrating_reg <= 1'b0;
            calibrated_reg  <= 1'b0;
            ppr_out_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            pulse_reg     <= pulse_next;
            win_cnt_reg   <= win_cnt_next;
            win_ms_reg    <= win_ms_next;
            calib_reg     <= calib_next;
            active_reg    <= active_next;
            ppr_reg       <= ppr_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
            elapsed_reg   <= elapsed_next;
            snap_now_reg  <= snap_now_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            if (out_load)
            begin
                status_reg      <= status_next;
                rpm_reg         <= speed_next;
                pos_reg         <= 32'($signed(pulse_next));
                calibrating_reg <= active_next;
                calibrated_reg  <= (ppr_next != '0);
                ppr_out_reg     <= ppr_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign rpm_q8         = rpm_reg;
    assign position_count = pos_reg;
    assign is_calibrating = calibrating_reg;
    assign is_calibrated  = calibrated_reg;
    assign pulses_per_rev = ppr_out_reg;

    `ASSERT_AT(a_pop_idle, clk, rst_n, pop |-> (state_reg == B_IDLE), "pop outside idle")
    `ASSERT_AT(a_div_no_result, clk, rst_n,
               (state_reg == B_DIV) |-> !out_valid_reg, "result pending during divide")
    `ASSERT_AT(a_mul_to_div, clk, rst_n,
               (state_reg == B_MUL) |=> (state_reg == B_DIV), "multiply not followed by divide")

endmodule

`default_nettype wire

FILE: hw/rtl/encoder_tachometer_with_calibration_core.sv
// Top level of the encoder tachometer with ppr calibration.
// Depends on etc_pkg, etc_front, etc_queue and etc_back.
//
//   channel | direction | handshake           | payload
//   in      | request   | in_valid / in_stall | cmd, b_level, now_ms
//   out     | result    | out_valid/out_stall | status, rpm_q8, position_count,
//           |           |                     | is_calibrating, is_calibrated,
//           |           |                     | pulses_per_rev
//   cfg     | write     | cfg_wr_en           | cfg_wr_data (sample_period_ms)
//
// Edge, start, finish and non-sampling time requests are served in the idle
// state. A window-closing time request goes on through the multiply, divide
// and finish states; the restoring divider gives one quotient bit per cycle.
// Results leave through the output register. Meanwhile the two-entry queue
// and front register take requests until full. Reset clears all but the item
// data registers; no clearing pass. A stalled result holds the back end.
`default_nettype none

module encoder_tachometer_with_calibration_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    cmd,
    input  wire logic          b_level,
    input  wire logic [31:0]   now_ms,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         status,
    output logic [31:0]        rpm_q8,
    output logic signed [31:0] position_count,
    output logic               is_calibrating,
    output logic               is_calibrated,
    output logic [16:0]        pulses_per_rev
);

    logic            q_full;
    logic            push;
    etc_pkg::item_t  push_item;
    logic            pop;
    etc_pkg::qhead_t head;

    etc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .b_level   (b_level),
        .now_ms    (now_ms),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    etc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    etc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .rpm_q8         (rpm_q8),
        .position_count (position_count),
        .is_calibrating (is_calibrating),
        .is_calibrated  (is_calibrated),
        .pulses_per_rev (pulses_per_rev)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for encoder_tachometer_with_calibration_core.
// Holds a scoreboard class that predicts every result from its own copy of the state.
// Depends on etc_pkg and the core RTL only.
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rpm;
        logic [31:0] position;
        logic        calibrating;
        logic        calibrated;
        logic [16:0] ppr;
    } tach_result_t;

    class tach_scoreboard;
        logic [15:0]  period;
        logic [31:0]  pulses;
        logic [31:0]  win_count;
        logic [31:0]  win_ms;
        logic [16:0]  cal_cnt;
        logic         cal_on;
        logic [16:0]  ppr;
        logic [31:0]  speed;
        int           errors;
        tach_result_t expected[$];

        function new();
            period    = etc_pkg::PERIOD_RESET;
            pulses    = '0;
            win_count = '0;
            win_ms    = '0;
            cal_cnt   = '0;
            cal_on    = 1'b0;
            ppr       = '0;
            speed     = '0;
            errors    = 0;
        endfunction

        function void set_period(logic [15:0] p);
            period = p;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_request(etc_pkg::kind_t k, logic b, logic [31:0] now);
            logic [31:0]  elapsed;
            logic [31:0]  delta;
            logic [31:0]  mag;
            logic [63:0]  num;
            logic [63:0]  den;
            logic [63:0]  quo;
            tach_result_t r;
            r.status = etc_pkg::ST_OK;
            case (k)
                etc_pkg::KIND_EDGE: begin
                    pulses = b ? pulses - 32'd1 : pulses + 32'd1;
                    if (cal_on && cal_cnt != etc_pkg::CAL_MAX)
                        cal_cnt = cal_cnt + 17'd1;
                end
                etc_pkg::KIND_TIME: begin
                    elapsed = now - win_ms;
                    if (elapsed == 32'd0 || ppr == 17'd0)
                        speed = '0;
                    else if (elapsed >= 32'(period)) begin
                        delta = pulses - win_count;
                        mag   = delta[31] ? ~delta + 32'd1 : delta;
                        num   = 64'(mag) * 64'(etc_pkg::RPM_SCALE);
                        den   = 64'(elapsed) * 64'(ppr);
                        quo   = num / den;
                        speed = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                        win_count = pulses;
                        win_ms    = now;
                    end
                end
                etc_pkg::KIND_START: begin
                    if (cal_on)
                        r.status = etc_pkg::ST_ALREADY;
                    else begin
                        cal_cnt  = '0;
                        cal_on   = 1'b1;
                        r.status = etc_pkg::ST_STARTED;
                    end
                end
                default: begin
                    if (!cal_on)
                        r.status = etc_pkg::ST_NOT_CAL;
                    else begin
                        cal_on    = 1'b0;
                        win_count = pulses;
                        win_ms    = now;
                        speed     = '0;
                        if (cal_cnt == 17'd0 || cal_cnt > etc_pkg::PPR_MAX)
                            r.status = etc_pkg::ST_INVALID;
                        else begin
                            ppr      = cal_cnt;
                            r.status = etc_pkg::ST_SAVED;
                        end
                    end
                end
            endcase
            r.rpm         = speed;
            r.position    = pulses;
            r.calibrating = cal_on;
            r.calibrated  = (ppr != 17'd0);
            r.ppr         = ppr;
            expected.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("tb: mismatch: %s", msg);
        endtask

        task check_result(tach_result_t got);
            tach_result_t e;
            if (expected.size() == 0) begin
                report("result with no request pending");
                return;
            end
            e = expected.pop_front();
            if (got.status !== e.status)
                report($sformatf("status got %0d want %0d", got.status, e.status));
            if (got.rpm !== e.rpm)
                report($sformatf("rpm_q8 got %0d want %0d", got.rpm, e.rpm));
            if (got.position !== e.position)
                report($sformatf("position_count got %0d want %0d",
                                 $signed(got.position), $signed(e.position)));
            if (got.calibrating !== e.calibrating)
                report($sformatf("is_calibrating got %b want %b",
                                 got.calibrating, e.calibrating));
            if (got.calibrated !== e.calibrated)
                report($sformatf("is_calibrated got %b want %b",
                                 got.calibrated, e.calibrated));
            if (got.ppr !== e.ppr)
                report($sformatf("pulses_per_rev got %0d want %0d", got.ppr, e.ppr));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = '0;
    logic               b_level = 1'b0;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [31:0]        rpm_q8;
    logic signed [31:0] position_count;
    logic               is_calibrating;
    logic               is_calibrated;
    logic [16:0]        pulses_per_rev;

    tach_scoreboard sb = new();
    tach_result_t   seen;
    logic           send_idle = 1'b0;
    logic           recv_stall = 1'b0;
    int             send_pct = 78;
    int             stall_pct = 78;
    logic [31:0]    cur_ms = '0;
    int             cycles = 0;

    encoder_tachometer_with_calibration_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .b_level        (b_level),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .rpm_q8         (rpm_q8),
        .position_count (position_count),
        .is_calibrating (is_calibrating),
        .is_calibrated  (is_calibrated),
        .pulses_per_rev (pulses_per_rev)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check on acceptance, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen = '{status, rpm_q8, position_count, is_calibrating,
                         is_calibrated, pulses_per_rev};
                sb.check_result(seen);
            end
            out_stall <= recv_stall && ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_req(etc_pkg::kind_t k, logic b, logic [31:0] t);
        while (send_idle && $urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= k;
        b_level  <= b;
        now_ms   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(k, b, t);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // idle first; wait until every pending result is checked, so no request is left in the back end
    task automatic write_period(logic [15:0] v);
        wait_results();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_period(v);
    endtask

    task automatic calibrate(int n, logic [31:0] t);
        send_req(etc_pkg::KIND_START, $urandom_range(0, 1), $urandom);
        repeat (n) send_req(etc_pkg::KIND_EDGE, $urandom_range(0, 1), $urandom);
        send_req(etc_pkg::KIND_FINISH, $urandom_range(0, 1), t);
    endtask

    function automatic logic [31:0] next_gap();
        logic [31:0] p;
        p = 32'(sb.period);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(1, p + 1);
            2:       return $urandom;
            default: return p + $urandom_range(0, p / 2 + 3);
        endcase
    endfunction

    task automatic run_directed();
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'd0);
        send_req(etc_pkg::KIND_TIME, 1'b1, 32'hFFFF_FFFF);
        send_req(etc_pkg::KIND_FINISH, 1'b0, 32'd5);
        send_req(etc_pkg::KIND_START, 1'b0, 32'd0);
        send_req(etc_pkg::KIND_START, 1'b1, 32'd0);
        send_req(etc_pkg::KIND_FINISH, 1'b1, 32'd7);       // zero pulses counted
        send_req(etc_pkg::KIND_EDGE, 1'b1, 32'hFFFF_FFFF);
        send_req(etc_pkg::KIND_START, 1'b0, 32'd0);
        repeat (3) send_req(etc_pkg::KIND_EDGE, 1'b0, 32'd0);
        send_req(etc_pkg::KIND_EDGE, 1'b1, 32'd0);
        send_req(etc_pkg::KIND_FINISH, 1'b0, 32'd1000);    // ppr becomes 4
        repeat (2) send_req(etc_pkg::KIND_EDGE, 1'b0, 32'd0);
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'd1050);      // window too short
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'd1000);      // zero elapsed
        send_req(etc_pkg::KIND_TIME, 1'b1, 32'd1100);
        repeat (3) send_req(etc_pkg::KIND_EDGE, 1'b1, 32'd0);
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'hFFFF_FFFF);
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'h0000_0010); // ms counter wrapped, short
        send_req(etc_pkg::KIND_TIME, 1'b0, 32'h0000_0080);
    endtask

    task automatic rand_phase(int n);
        int   done;
        int   k;
        int   r;
        logic dir;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
                cur_ms = cur_ms + next_gap();
                calibrate(k, cur_ms);
                done += k + 2;
            end
            else if (r < 75) begin
                k   = $urandom_range(0, 30);
                dir = $urandom_range(0, 1);
                repeat (k)
                    send_req(etc_pkg::KIND_EDGE, ($urandom_range(0, 9) < 8) ? dir : !dir,
                             $urandom);
                cur_ms = cur_ms + next_gap();
                send_req(etc_pkg::KIND_TIME, $urandom_range(0, 1), cur_ms);
                done += k + 1;
            end
            else begin
                send_req(etc_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                         $urandom_range(0, 1) ? cur_ms : $urandom);
                done++;
            end
            if ($urandom_range(0, 39) == 0)
                wait_results();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        // no minimum period; ppr of one drives the speed into saturation
        write_period(16'd0);
        cur_ms = 32'hFFFF_FFF0;
        calibrate(1, cur_ms);
        repeat (300) send_req(etc_pkg::KIND_EDGE, 1'b0, $urandom);
        send_req(etc_pkg::KIND_TIME, 1'b0, cur_ms);
        send_req(etc_pkg::KIND_TIME, 1'b0, cur_ms + 32'd1);
        repeat (20) send_req(etc_pkg::KIND_EDGE, 1'b1, $urandom);
        send_req(etc_pkg::KIND_TIME, 1'b1, cur_ms + 32'd2);
        cur_ms = cur_ms + 32'd2;
        rand_phase(60);

        write_period(16'hFFFF);
        send_idle = 1'b1;
        rand_phase(60);

        write_period(16'd1);
        send_idle = 1'b0;
        rand_phase(60);

        write_period(16'($urandom_range(2, 65534)));
        recv_stall = 1'b1;
        rand_phase(60);

        // both sides idle now and then
        write_period(16'd10);
        send_idle = 1'b1;
        send_pct  = 18;
        stall_pct = 18;
        rand_phase(60);

        write_period(16'($urandom));
        recv_stall = 1'b0;
        send_pct   = 78;
        stall_pct  = 78;
        rand_phase(60);

        write_period(16'd100);
        send_idle  = 1'b0;
        recv_stall = 1'b1;
        rand_phase(60);

        write_period(16'hFFFF);
        send_idle = 1'b1;
        send_pct  = 18;
        stall_pct = 18;
        rand_phase(60);

        wait_results();
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
